@@ hw/rtl/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
// Register indexes, field widths, reset values and the structs between modules.
// No dependencies; compile first.
`default_nettype none

package uer_pkg;

  // Configuration port shape
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD_CM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT_US   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PERIOD_US = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH_US  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM         = 3'd5;

  // Field widths
  localparam int WLEN_W  = 6;
  localparam int CM_W    = 8;
  localparam int TICK_W  = 16;

  // Register reset values
  localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH     = 6'd30;
  localparam logic [CM_W-1:0]   RST_NEAR_THRESHOLD_CM = 8'd15;
  localparam logic [TICK_W-1:0] RST_ECHO_TIMEOUT_US   = 16'd3000;
  localparam logic [TICK_W-1:0] RST_TRIGGER_PERIOD_US = 16'd30000;
  localparam logic [CM_W-1:0]   RST_TRIGGER_WIDTH_US  = 8'd10;
  localparam logic [CM_W-1:0]   RST_US_PER_CM         = 8'd58;

  localparam logic [CM_W-1:0] CM_MAX = 8'd255;

  // Default window store depth
  localparam int DEF_MAX_WINDOW = 32;

  // One result beat
  typedef struct packed {
    logic            trigger_level;
    logic            near_flag;
    logic            distance_valid;
    logic [CM_W-1:0] distance_cm;
    logic            average_valid;
    logic [CM_W-1:0] average_cm;
    logic            timeout_event;
  } out_item_t;

  // Control from the sequencer to the window unit
  typedef struct packed {
    logic push;
    logic clear;
  } win_ctl_t;

  // Status from the window unit back to the sequencer
  typedef struct packed {
    logic done;
    logic avg_valid;
  } win_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/uer_in_if.sv @@
// Input channel: one echo sample beat per microsecond tick.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface uer_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/uer_out_if.sv @@
// Output channel: one result beat per tick.
// Valid/ready handshake; widths follow uer_pkg.
`default_nettype none

interface uer_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_level;
  logic       near_flag;
  logic       distance_valid;
  logic [7:0] distance_cm;
  logic       average_valid;
  logic [7:0] average_cm;
  logic       timeout_event;

  modport source (output valid, output trigger_level, output near_flag,
                  output distance_valid, output distance_cm, output average_valid,
                  output average_cm, output timeout_event, input ready);
  modport sink   (input valid, input trigger_level, input near_flag,
                  input distance_valid, input distance_cm, input average_valid,
                  input average_cm, input timeout_event, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/uer_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the distance and window-average paths; no package needed.
`default_nettype none

module uer_div #(
  parameter int NumW = 16,
  parameter int DenW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] dividend_i,
  input  wire logic [DenW-1:0] divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [NumW-1:0]      quotient_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q, dvs_q;
  logic [DenW:0]   rem_sh, diff;
  logic            fits;

  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Flag the cycle right after the last quotient bit
      done_q <= !start_i && busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift one dividend bit into the remainder per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= fits ? diff[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/uer_window.sv @@
// Sliding window of distances: synchronous store, fill count, oldest pointer, sum.
// Replace steps read the oldest entry, then subtract it and write back. Uses uer_pkg.
`default_nettype none

module uer_window #(
  parameter int MaxWindow = uer_pkg::DEF_MAX_WINDOW,
  localparam int IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1,
  localparam int CntW = $clog2(MaxWindow + 1),
  localparam int SumW = 8 + $clog2(MaxWindow + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire uer_pkg::win_ctl_t ctl_i,
  input  wire logic [7:0]        dist_i,
  input  wire logic [CntW-1:0]   len_i,
  output uer_pkg::win_sts_t      sts_o,
  output logic [SumW-1:0]        sum_o
);

  import uer_pkg::*;

  typedef enum logic {W_IDLE, W_RMW} wstate_e;

  wstate_e         state_q;
  logic [CntW-1:0] fill_q;
  logic [IdxW-1:0] ptr_q, slot_q, slot_c;
  logic [SumW-1:0] sum_q;
  logic [7:0]      dist_q, rdata_q;
  win_sts_t        sts_q;
  logic [SumW:0]   sum_rmw;
  logic [CntW-1:0] slot_inc;
  logic            filling;

  logic [7:0]      mem [MaxWindow];
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [7:0]      wdata;

  assign filling  = fill_q < len_i;
  assign slot_c   = (CntW'(ptr_q) >= len_i) ? '0 : ptr_q;
  assign slot_inc = CntW'(slot_q) + 1'b1;
  assign sum_rmw  = {1'b0, sum_q} + (SumW + 1)'(dist_q) - (SumW + 1)'(rdata_q);

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = dist_q;
    case (state_q)
      W_IDLE: begin
        if (ctl_i.push && filling) begin
          we    = 1'b1;
          waddr = fill_q[IdxW-1:0];
          wdata = dist_i;
        end
      end
      W_RMW: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[slot_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      fill_q  <= '0;
      ptr_q   <= '0;
      sum_q   <= '0;
      sts_q   <= '0;
    end else begin
      sts_q.done      <= (state_q == W_RMW) ||
                         (state_q == W_IDLE && !ctl_i.clear && ctl_i.push && filling);
      sts_q.avg_valid <= (state_q == W_RMW);
      case (state_q)
        W_IDLE: begin
          if (ctl_i.clear) begin
            fill_q <= '0;
            ptr_q  <= '0;
            sum_q  <= '0;
          end else if (ctl_i.push) begin
            if (filling) begin
              sum_q  <= sum_q + SumW'(dist_i);
              fill_q <= fill_q + 1'b1;
            end else begin
              state_q <= W_RMW;
            end
          end
        end
        W_RMW: begin
          sum_q   <= sum_rmw[SumW-1:0];
          ptr_q   <= (slot_inc >= len_i) ? '0 : slot_inc[IdxW-1:0];
          state_q <= W_IDLE;
        end
        default: begin
          state_q <= W_IDLE;
        end
      endcase
    end
  end

  // Hold the distance and slot for the write-back step
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && ctl_i.push) begin
      dist_q <= dist_i;
      slot_q <= slot_c;
    end
  end

  assign sts_o = sts_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger: trigger generator, echo pulse timer, distance and
// window average. Depends on uer_pkg, uer_in_if, uer_out_if, uer_div, uer_window.
//
// Usage:
//   in_i  : one beat per microsecond tick carrying the sampled echo level.
//   out_o : exactly one result beat per input beat, in order: trigger level,
//           near flag, distance (valid on a completed pulse), window average
//           (valid when a new one is made) and the timeout event.
//   cfg   : cfg_we_i writes cfg_data_i into register cfg_idx_i.
//           Write only while no beat is in flight. Writing the window length
//           empties the window; the last average is kept.
// Sequencing:
//   A tick with no completed pulse goes from accept straight to the output
//   register step (S_PUT). A tick that ends a pulse runs the shared divider for
//   the distance, then a window fill or a window read-modify-write, and with a
//   full window the divider again for the average. The next beat is not taken
//   before the current one is through.
//   The input takes a new beat as soon as the sequencer is back in idle.
// Reset: all control state, counters and the window fill count clear; the
//   window store itself is not cleared (every entry is written before read).
// Stall: a finished result waits in the output register; the next tick is
//   worked on meanwhile and holds before the output until it drains.
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int MaxWindow = uer_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  uer_in_if.sink                              in_i,
  uer_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import uer_pkg::*;

  localparam int CntW = $clog2(MaxWindow + 1);
  localparam int SumW = 8 + $clog2(MaxWindow + 1);
  localparam int NumW = (SumW > TICK_W) ? SumW : TICK_W;
  localparam int DenW = (CntW > CM_W) ? CntW : CM_W;

  typedef enum logic [2:0] {S_IDLE, S_DIST, S_WIN, S_AVG, S_PUT} state_e;

  // Configuration registers
  logic [WLEN_W-1:0] wlen_q;
  logic [CM_W-1:0]   near_thr_q;
  logic [TICK_W-1:0] timeout_q;
  logic [TICK_W-1:0] period_q;
  logic [CM_W-1:0]   trig_width_q;
  logic [CM_W-1:0]   us_per_cm_q;

  // Tick state
  state_e            state_q;
  logic [TICK_W-1:0] pcnt_q;
  logic              echo_prev_q, echo_act_q, tpend_q;
  logic [TICK_W-1:0] pulse_q;
  logic [CM_W-1:0]   last_dist_q, last_avg_q;
  out_item_t         res_q, out_q;
  logic              out_valid_q;

  // Tick logic, evaluated on the accepted beat
  logic              accept, echo;
  logic [TICK_W:0]   pcnt_inc;
  logic [TICK_W-1:0] pcnt_d, pulse_d;
  logic              trig, rise, act_d, tev, fall, measure;
  out_item_t         res_init, out_next;

  // Shared divider and window
  logic              div_start, div_busy, div_done;
  logic [NumW-1:0]   div_num, div_quo;
  logic [DenW-1:0]   div_den;
  logic [CntW-1:0]   len_eff;
  logic [CM_W-1:0]   dist_c;
  logic              near_c, out_free;
  win_ctl_t          win_ctl;
  win_sts_t          win_sts;
  logic [SumW-1:0]   win_sum;

  assign accept = in_i.valid && in_i.ready;
  assign echo   = in_i.echo_level;

  assign trig     = pcnt_q < {8'b0, trig_width_q};
  assign pcnt_inc = {1'b0, pcnt_q} + 1'b1;
  assign pcnt_d   = (pcnt_inc >= {1'b0, period_q}) ? '0 : pcnt_inc[TICK_W-1:0];

  assign rise  = echo && !echo_prev_q;
  assign act_d = rise || echo_act_q;
  always_comb begin
    if (rise) begin
      pulse_d = TICK_W'(1);
    end else if (echo && echo_act_q && pulse_q != '1) begin
      pulse_d = pulse_q + 1'b1;
    end else begin
      pulse_d = pulse_q;
    end
  end
  assign tev     = echo && act_d && !tpend_q && (pulse_d >= timeout_q);
  assign fall    = !echo && echo_prev_q && act_d;
  // A pulse that already timed out is dropped when it falls
  assign measure = fall && !tpend_q;

  // Window length zero acts as one; clamp to the store depth
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = CntW'(1);
    end else if (int'(wlen_q) > MaxWindow) begin
      len_eff = CntW'(MaxWindow);
    end else begin
      len_eff = CntW'(wlen_q);
    end
  end

  // Distance: zero divisor and overflow both saturate
  assign dist_c = (us_per_cm_q == '0 || |div_quo[NumW-1:CM_W]) ? CM_MAX
                                                               : div_quo[CM_W-1:0];

  // Divider runs on the pulse length at accept, on the window sum later
  assign div_start = (accept && measure) ||
                     (state_q == S_WIN && win_sts.done && win_sts.avg_valid);
  assign div_num   = (state_q == S_IDLE) ? NumW'(pulse_d) : NumW'(win_sum);
  assign div_den   = (state_q == S_IDLE) ? DenW'(us_per_cm_q) : DenW'(len_eff);

  assign win_ctl.push  = (state_q == S_DIST) && div_done;
  assign win_ctl.clear = cfg_we_i && (cfg_idx_i == CFG_WINDOW_LENGTH);

  assign near_c   = (last_dist_q != '0) && (last_dist_q <= near_thr_q) && !tpend_q;
  assign out_free = !out_valid_q || out_o.ready;

  // Fresh result for an accepted tick, and the finished beat for the output
  always_comb begin
    res_init               = '0;
    res_init.trigger_level = trig;
    res_init.timeout_event = tev;
    out_next               = res_q;
    out_next.near_flag     = near_c;
    out_next.distance_cm   = last_dist_q;
    out_next.average_cm    = last_avg_q;
  end

  uer_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  uer_window #(
    .MaxWindow (MaxWindow)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (win_ctl),
    .dist_i (dist_c),
    .len_i  (len_eff),
    .sts_o  (win_sts),
    .sum_o  (win_sum)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q       <= RST_WINDOW_LENGTH;
      near_thr_q   <= RST_NEAR_THRESHOLD_CM;
      timeout_q    <= RST_ECHO_TIMEOUT_US;
      period_q     <= RST_TRIGGER_PERIOD_US;
      trig_width_q <= RST_TRIGGER_WIDTH_US;
      us_per_cm_q  <= RST_US_PER_CM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_LENGTH:     wlen_q       <= cfg_data_i[WLEN_W-1:0];
        CFG_NEAR_THRESHOLD_CM: near_thr_q   <= cfg_data_i[CM_W-1:0];
        CFG_ECHO_TIMEOUT_US:   timeout_q    <= cfg_data_i[TICK_W-1:0];
        CFG_TRIGGER_PERIOD_US: period_q     <= cfg_data_i[TICK_W-1:0];
        CFG_TRIGGER_WIDTH_US:  trig_width_q <= cfg_data_i[CM_W-1:0];
        CFG_US_PER_CM:         us_per_cm_q  <= cfg_data_i[CM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: tick update, distance divide, window step, average divide, output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pcnt_q      <= '0;
      echo_prev_q <= 1'b0;
      echo_act_q  <= 1'b0;
      pulse_q     <= '0;
      tpend_q     <= 1'b0;
      last_dist_q <= '0;
      last_avg_q  <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Load a finished beat, or drop the one just taken
      if (state_q == S_PUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            pcnt_q      <= pcnt_d;
            echo_prev_q <= echo;
            pulse_q     <= pulse_d;
            echo_act_q  <= fall ? 1'b0 : act_d;
            if (tev) begin
              tpend_q     <= 1'b1;
              last_dist_q <= '0;
            end else if (fall) begin
              tpend_q <= 1'b0;
            end
            res_q   <= res_init;
            state_q <= measure ? S_DIST : S_PUT;
          end
        end
        S_DIST: begin
          if (div_done) begin
            last_dist_q          <= dist_c;
            res_q.distance_valid <= 1'b1;
            state_q              <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_sts.done) begin
            state_q <= win_sts.avg_valid ? S_AVG : S_PUT;
          end
        end
        S_AVG: begin
          if (div_done) begin
            last_avg_q          <= div_quo[CM_W-1:0];
            res_q.average_valid <= 1'b1;
            state_q             <= S_PUT;
          end
        end
        S_PUT: begin
          // Hold until the output register drains
          if (out_free) begin
            out_q   <= out_next;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.trigger_level  = out_q.trigger_level;
  assign out_o.near_flag      = out_q.near_flag;
  assign out_o.distance_valid = out_q.distance_valid;
  assign out_o.distance_cm    = out_q.distance_cm;
  assign out_o.average_valid  = out_q.average_valid;
  assign out_o.average_cm     = out_q.average_cm;
  assign out_o.timeout_event  = out_q.timeout_event;

  // A timeout needs a high echo, a measurement a falling one
  a_no_dist_on_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.distance_valid && out_o.timeout_event))
    else $error("distance and timeout in the same beat");

  // An average is only made from a fresh distance
  a_avg_needs_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.average_valid) |-> out_o.distance_valid)
    else $error("average without distance");

  // The shared divider is never restarted mid-operation
  a_div_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for ultrasonic_echo_ranger: echo samples in, one result beat per tick out.
// Predicts every tick in-bench and compares each field; random stalls on both channels.
// Depends on uer_pkg, uer_in_if, uer_out_if and the ranger RTL.

module tb;
  import uer_pkg::*;

  localparam int          MAX_WIN     = DEF_MAX_WINDOW;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 64;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  uer_in_if  echo_if ();
  uer_out_if res_if ();

  ultrasonic_echo_ranger u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (echo_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Echo levels waiting to be sent, and the tick results still owed by the block.
  logic      echo_script[$];
  out_item_t expected_ticks[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Idle control: percent chance per cycle of starting a stall burst; quiet_tail turns it off.
  int unsigned idle_pct   = 0;
  bit          quiet_tail = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned out_gap    = 0;

  // Register shadow of the block's configuration.
  logic [WLEN_W-1:0] win_len;
  logic [CM_W-1:0]   near_cm;
  logic [TICK_W-1:0] tmo_us;
  logic [TICK_W-1:0] trig_period;
  logic [CM_W-1:0]   trig_width;
  logic [CM_W-1:0]   cm_div;

  // Predicted ranger state.
  logic [TICK_W-1:0] period_cnt;
  logic              echo_prev;
  logic              echo_busy;
  logic [TICK_W-1:0] pulse_len;
  logic              tmo_pending;
  logic [CM_W-1:0]   last_dist;
  logic [CM_W-1:0]   win_mem[MAX_WIN];
  int unsigned       fill_cnt;
  int unsigned       oldest;
  int unsigned       run_sum;
  logic [CM_W-1:0]   last_avg;

  // Clock: period 10.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the ranger by one microsecond tick and return what it should report.
  function automatic out_item_t range_tick(input logic echo);
    out_item_t   res;
    int unsigned quo;
    int unsigned depth;
    res = '0;

    // Trigger is high for the first trig_width counts of each period; a period
    // of 0 or 1 pins the counter at zero.
    res.trigger_level = (period_cnt < TICK_W'(trig_width));
    if (32'(period_cnt) + 1 >= 32'(trig_period)) period_cnt = '0;
    else period_cnt = period_cnt + 1'b1;

    // Time the pulse: the rising tick counts as one, and the count saturates.
    if (echo && !echo_prev) begin
      echo_busy = 1'b1;
      pulse_len = TICK_W'(1);
    end else if (echo && echo_busy && pulse_len != '1) begin
      pulse_len = pulse_len + 1'b1;
    end

    // Timeout fires once per pulse, on the rising tick too when the limit is 0 or 1.
    if (echo && echo_busy && !tmo_pending && pulse_len >= tmo_us) begin
      tmo_pending         = 1'b1;
      last_dist           = '0;
      res.timeout_event   = 1'b1;
    end

    // On the falling edge either drop a timed-out pulse or measure and feed the window.
    if (!echo && echo_prev && echo_busy) begin
      echo_busy = 1'b0;
      if (tmo_pending) begin
        tmo_pending = 1'b0;
      end else begin
        quo = (cm_div == 0) ? 255 : pulse_len / cm_div;
        if (quo > 255) quo = 255;
        last_dist          = CM_W'(quo);
        res.distance_valid = 1'b1;
        // Out-of-range window lengths clamp to 1..MAX_WIN.
        depth = (win_len == 0) ? 1 : ((win_len > MAX_WIN) ? MAX_WIN : win_len);
        if (fill_cnt < depth) begin
          win_mem[fill_cnt] = last_dist;
          run_sum           = run_sum + last_dist;
          fill_cnt++;
        end else begin
          if (oldest >= depth) oldest = 0;
          run_sum           = run_sum + last_dist - win_mem[oldest];
          win_mem[oldest]   = last_dist;
          oldest            = (oldest + 1 >= depth) ? 0 : oldest + 1;
          last_avg          = CM_W'(run_sum / depth);
          res.average_valid = 1'b1;
        end
      end
    end
    echo_prev = echo;

    res.near_flag   = (last_dist != 0) && (last_dist <= near_cm) && !tmo_pending;
    res.distance_cm = last_dist;
    res.average_cm  = last_avg;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Write all six registers, one per cycle, and mirror them in the shadow copy.
  task automatic program_regs(input int unsigned wl, input int unsigned nr,
                              input int unsigned tmo, input int unsigned per,
                              input int unsigned wid, input int unsigned upc);
    int unsigned vals[6];
    logic [CFG_IDX_W-1:0] idxs[6];
    vals = '{wl, nr, tmo, per, wid, upc};
    idxs = '{CFG_WINDOW_LENGTH, CFG_NEAR_THRESHOLD_CM, CFG_ECHO_TIMEOUT_US,
             CFG_TRIGGER_PERIOD_US, CFG_TRIGGER_WIDTH_US, CFG_US_PER_CM};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= CFG_DATA_W'(vals[i]);
      case (idxs[i])
        CFG_WINDOW_LENGTH: begin
          // A window length write empties the window but keeps the last average.
          win_len  = WLEN_W'(vals[i]);
          fill_cnt = 0;
          oldest   = 0;
          run_sum  = 0;
        end
        CFG_NEAR_THRESHOLD_CM: near_cm     = CM_W'(vals[i]);
        CFG_ECHO_TIMEOUT_US:   tmo_us      = TICK_W'(vals[i]);
        CFG_TRIGGER_PERIOD_US: trig_period = TICK_W'(vals[i]);
        CFG_TRIGGER_WIDTH_US:  trig_width  = CM_W'(vals[i]);
        CFG_US_PER_CM:         cm_div      = CM_W'(vals[i]);
        default: ;
      endcase
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pulse(input int unsigned high, input int unsigned low);
    repeat (high) echo_script.push_back(1'b1);
    repeat (low) echo_script.push_back(1'b0);
  endtask

  // Mostly well-formed pulses with random lengths, some hugging the timeout,
  // with bursts of random levels mixed in.
  task automatic queue_random_ticks(input int unsigned target);
    int unsigned added;
    int unsigned pick;
    int unsigned high;
    int unsigned low;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        high = $urandom_range(1, 6);
        repeat (high) echo_script.push_back(1'($urandom_range(1)));
        added += high;
      end else begin
        if (pick < 55) high = $urandom_range(1, 6);
        else if (pick < 75 && tmo_us != 0 && tmo_us < 60)
          high = $urandom_range((tmo_us > 2) ? tmo_us - 2 : 1, tmo_us + 2);
        else if (pick < 92) high = $urandom_range(1, 20);
        else high = $urandom_range(20, 60);
        low = $urandom_range(1, 4);
        queue_pulse(high, low);
        added += high + low;
      end
    end
  endtask

  // Block until every queued sample is accepted and every result has come back.
  task automatic drain();
    while (echo_script.size() != 0 || echo_if.valid || expected_ticks.size() != 0)
      @(posedge clk_i);
  endtask

  // Input driver: hold a beat until taken, otherwise idle or send the next sample.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      echo_if.valid      <= 1'b0;
      echo_if.echo_level <= 1'b0;
      in_gap             <= 0;
    end else begin
      // Predict at acceptance so the expectations follow beat order.
      if (echo_if.valid && echo_if.ready)
        expected_ticks.push_back(range_tick(echo_if.echo_level));
      if (!echo_if.valid || echo_if.ready) begin
        if (in_gap != 0) begin
          echo_if.valid <= 1'b0;
          in_gap        <= in_gap - 1;
        end else if (echo_script.size() != 0 && !quiet_tail && idle_pct != 0 &&
                     $urandom_range(99) < idle_pct) begin
          echo_if.valid <= 1'b0;
          in_gap        <= $urandom_range(18);
        end else if (echo_script.size() != 0) begin
          echo_if.valid      <= 1'b1;
          echo_if.echo_level <= echo_script.pop_front();
        end else begin
          echo_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest expectation, and stall at random.
  always @(posedge clk_i) begin : result_mon
    out_item_t seen;
    out_item_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      out_gap      <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen = {res_if.trigger_level, res_if.near_flag, res_if.distance_valid,
                res_if.distance_cm, res_if.average_valid, res_if.average_cm,
                res_if.timeout_event};
        if (expected_ticks.size() == 0) begin
          $display("%0t: result beat with none expected, actual %h", $time, seen);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("trigger_level", want.trigger_level, seen.trigger_level);
          check_field("near_flag", want.near_flag, seen.near_flag);
          check_field("distance_valid", want.distance_valid, seen.distance_valid);
          check_field("distance_cm", want.distance_cm, seen.distance_cm);
          check_field("average_valid", want.average_valid, seen.average_valid);
          check_field("average_cm", want.average_cm, seen.average_cm);
          check_field("timeout_event", want.timeout_event, seen.timeout_event);
        end
      end
      if (out_gap != 0) begin
        res_if.ready <= 1'b0;
        out_gap      <= out_gap - 1;
      end else if (!quiet_tail && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        res_if.ready <= 1'b0;
        out_gap      <= $urandom_range(18);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ultrasonic_echo_ranger] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned wl, nr, tmo, per, wid, upc, depth;

    // Drive every input to a known level before the first edge.
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_WINDOW_LENGTH;
    cfg_data           = '0;
    echo_if.valid      = 1'b0;
    echo_if.echo_level = 1'b0;
    res_if.ready       = 1'b0;

    // Reset state of the shadow registers and the predicted ranger.
    win_len     = RST_WINDOW_LENGTH;
    near_cm     = RST_NEAR_THRESHOLD_CM;
    tmo_us      = RST_ECHO_TIMEOUT_US;
    trig_period = RST_TRIGGER_PERIOD_US;
    trig_width  = RST_TRIGGER_WIDTH_US;
    cm_div      = RST_US_PER_CM;
    period_cnt  = '0;
    echo_prev   = 1'b0;
    echo_busy   = 1'b0;
    pulse_len   = '0;
    tmo_pending = 1'b0;
    last_dist   = '0;
    fill_cnt    = 0;
    oldest      = 0;
    run_sum     = 0;
    last_avg    = '0;
    for (int i = 0; i < MAX_WIN; i++) win_mem[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, a rise on the very first tick, short pulses that round to 0 cm.
    idle_pct = 10;
    queue_pulse(1, 1);
    queue_pulse(3, 2);
    drain();

    // Single-entry window, widest threshold, timeout at two ticks, shortest
    // legal trigger period and width: one-tick pulses measure 1 cm, longer ones time out.
    program_regs(1, 255, 2, 2, 1, 1);
    queue_pulse(1, 1);
    queue_pulse(1, 1);
    queue_pulse(3, 1);
    queue_pulse(2, 1);
    queue_pulse(1, 1);
    drain();

    // Zero divisor gives 255 cm, window length 0 acts as 1, threshold 0 never
    // flags near, period 0 pins the counter and width 0 never triggers.
    program_regs(0, 0, 65535, 0, 0, 0);
    queue_pulse(1, 1);
    queue_pulse(2, 1);
    drain();

    // Timeout 0 fires on the rising tick; period 1 with width 255 keeps the
    // trigger high; window length 63 acts as the full depth.
    program_regs(63, 255, 0, 1, 255, 255);
    queue_pulse(2, 1);
    queue_pulse(1, 1);
    drain();

    // Longest period, one tick per cm: a long pulse saturates at 255 cm, then a
    // 1 cm pulse closes a two-entry window.
    program_regs(2, 200, 65535, 65535, 255, 1);
    queue_pulse(300, 2);
    queue_pulse(1, 1);
    drain();

    // Random phases: new settings each time, window mostly short so averages flow.
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(11))
        0:       wl = 0;
        1:       wl = MAX_WIN;
        2:       wl = $urandom_range(MAX_WIN + 1, 63);
        3, 4:    wl = $urandom_range(5, MAX_WIN - 1);
        default: wl = $urandom_range(1, 4);
      endcase
      nr = $urandom_range(1) ? $urandom_range(255) : $urandom_range(20);
      case ($urandom_range(9))
        0:       tmo = 0;
        1:       tmo = 65535;
        default: tmo = $urandom_range(1, 30);
      endcase
      case ($urandom_range(9))
        0:       per = 65535;
        1:       per = $urandom_range(2, 65535);
        default: per = $urandom_range(40);
      endcase
      case ($urandom_range(9))
        0:       wid = 255;
        1:       wid = $urandom_range(255);
        default: wid = $urandom_range(50);
      endcase
      case ($urandom_range(9))
        0:       upc = 255;
        1:       upc = $urandom_range(255);
        default: upc = $urandom_range(6);
      endcase
      program_regs(wl, nr, tmo, per, wid, upc);

      // Leave one middle phase unstalled and drop stalls entirely for the last.
      idle_pct   = (phase == 2) ? 0 : 10;
      quiet_tail = (phase == 5);

      depth = (wl == 0) ? 1 : ((wl > MAX_WIN) ? MAX_WIN : wl);
      queue_random_ticks(16 + 2 * depth);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ultrasonic_echo_ranger] OK");
    end else begin
      $display("[ultrasonic_echo_ranger] ERROR");
    end
    $finish;
  end

endmodule
